### rtl/core/irfr_pkg.sv
package irfr_pkg;

    // Frame limits.
    localparam int MAX_FRAME   = 255;
    localparam int FIELD_COUNT = 8;

    // Widths that follow from the limits.
    localparam int CNT_W  = $clog2(MAX_FRAME + 1);
    localparam int FIDX_W = $clog2(FIELD_COUNT + 1);
    localparam int FSEL_W = (FIELD_COUNT > 1) ? $clog2(FIELD_COUNT) : 1;

    // Output field layout, fixed by the result format.
    localparam int NUM_DIST  = 8;
    localparam int DIST_W    = 32;
    localparam int STATUS_W  = 3;
    localparam int FCOUNT_W  = 4;
    localparam int OUT_W     = STATUS_W + 1 + FCOUNT_W + NUM_DIST * DIST_W;
    localparam int DIST_LSB  = STATUS_W + 1 + FCOUNT_W;

    // Byte codes.
    localparam logic [7:0] START_BYTE   = 8'h05;
    localparam logic [7:0] END_BYTE     = 8'h03;
    localparam logic [7:0] FLAG_OK_BYTE = 8'h30;
    localparam logic [7:0] SEP_BYTE     = 8'h3B;
    localparam logic [7:0] DIGIT_LO     = 8'h30;
    localparam logic [7:0] DIGIT_HI     = 8'h39;

    // Input kinds carried on the input tuser bit.
    localparam logic MODE_BYTE    = 1'b0;
    localparam logic MODE_TIMEOUT = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_FLAG    = 3'd1,
        ST_LRC     = 3'd2,
        ST_TIMEOUT = 3'd3,
        ST_LONG    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        PH_HUNT = 3'b001,
        PH_BODY = 3'b010,
        PH_LRC  = 3'b100
    } t_phase;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        t_status                         status;
        logic                            send_ack;
        logic [FCOUNT_W-1:0]             field_count;
        logic [NUM_DIST-1:0][DIST_W-1:0] distance;
    } t_result;

    // Appends one decimal digit to a value, saturating at all ones.
    function automatic logic [DIST_W-1:0] mul10_add_sat(input logic [DIST_W-1:0] v,
                                                        input logic [3:0] d);
        logic [DIST_W+3:0] wide;
        wide = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {{DIST_W{1'b0}}, d};
        if (wide[DIST_W+3:DIST_W] != 4'b0) begin
            return {DIST_W{1'b1}};
        end
        return wide[DIST_W-1:0];
    endfunction

endpackage

### rtl/core/irfr_in_stage.sv
module irfr_in_stage
    import irfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,
    input  logic       i_s_tuser,
    input  logic       i_take,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;

    // The register refills in the same cycle that its item moves on.
    assign o_s_tready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_item.mode    <= i_s_tuser;
            r_item.rx_byte <= i_s_tdata;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### rtl/core/irfr_parser.sv
module irfr_parser
    import irfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    output logic    o_res_valid,
    output t_result o_result
);

    t_phase            r_phase,       n_phase;
    logic [7:0]        r_lrc,         n_lrc;
    logic [CNT_W-1:0]  r_byte_count,  n_byte_count;
    logic              r_flag_good,   n_flag_good;
    logic              r_saw_flag,    n_saw_flag;
    logic [FIDX_W-1:0] r_field_index, n_field_index;
    logic [DIST_W-1:0] r_field_values [FIELD_COUNT];

    logic              clear_fields;
    logic              digit_en;
    t_status           status;
    logic [7:0]        b;
    logic              is_digit;
    logic [FSEL_W-1:0] fsel;
    logic [DIST_W-1:0] cur_value;
    logic [DIST_W-1:0] field_out [NUM_DIST];

    assign b        = i_item.rx_byte;
    assign is_digit = (b >= DIGIT_LO) && (b <= DIGIT_HI);
    assign fsel     = r_field_index[FSEL_W-1:0];
    assign cur_value = r_field_values[fsel];

    always_comb begin
        n_phase       = r_phase;
        n_lrc         = r_lrc;
        n_byte_count  = r_byte_count;
        n_flag_good   = r_flag_good;
        n_saw_flag    = r_saw_flag;
        n_field_index = r_field_index;
        clear_fields  = 1'b0;
        digit_en      = 1'b0;
        o_res_valid   = 1'b0;
        status        = ST_OK;

        if (i_step) begin
            if (i_item.mode == MODE_TIMEOUT) begin
                o_res_valid = 1'b1;
                status      = ST_TIMEOUT;
                n_phase     = PH_HUNT;
            end else if (r_phase == PH_HUNT) begin
                if (b == START_BYTE) begin
                    n_phase      = PH_BODY;
                    n_byte_count = CNT_W'(1);
                    clear_fields = 1'b1;
                end
            end else if (r_byte_count >= CNT_W'(MAX_FRAME)) begin
                o_res_valid = 1'b1;
                status      = ST_LONG;
                n_phase     = PH_HUNT;
            end else begin
                n_byte_count = r_byte_count + CNT_W'(1);
                unique case (r_phase)
                    PH_LRC: begin
                        o_res_valid = 1'b1;
                        if (!r_flag_good) begin
                            status = ST_FLAG;
                        end else if (b != r_lrc) begin
                            status = ST_LRC;
                        end else begin
                            status = ST_OK;
                        end
                        n_phase = PH_HUNT;
                    end
                    PH_BODY: begin
                        n_lrc = r_lrc ^ b;
                        if (!r_saw_flag) begin
                            n_saw_flag  = 1'b1;
                            n_flag_good = (b == FLAG_OK_BYTE);
                            if (b == END_BYTE) begin
                                n_phase = PH_LRC;
                            end
                        end else if (is_digit) begin
                            digit_en = (r_field_index < FIDX_W'(FIELD_COUNT));
                        end else if (b == SEP_BYTE || b == END_BYTE) begin
                            if (r_field_index < FIDX_W'(FIELD_COUNT)) begin
                                n_field_index = r_field_index + FIDX_W'(1);
                            end
                            if (b == END_BYTE) begin
                                n_phase = PH_LRC;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_HUNT;
                    end
                endcase
            end

            // Every way back to hunting starts the next frame from scratch.
            if (n_phase == PH_HUNT) begin
                n_lrc         = 8'h00;
                n_byte_count  = '0;
                n_flag_good   = 1'b0;
                n_saw_flag    = 1'b0;
                n_field_index = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HUNT;
            r_lrc         <= 8'h00;
            r_byte_count  <= '0;
            r_flag_good   <= 1'b0;
            r_saw_flag    <= 1'b0;
            r_field_index <= '0;
        end else begin
            r_phase       <= n_phase;
            r_lrc         <= n_lrc;
            r_byte_count  <= n_byte_count;
            r_flag_good   <= n_flag_good;
            r_saw_flag    <= n_saw_flag;
            r_field_index <= n_field_index;
        end
    end

    // Field values reach the result only below the field index, which reset clears.
    always_ff @(posedge i_clk) begin
        if (clear_fields) begin
            for (int k = 0; k < FIELD_COUNT; k++) begin
                r_field_values[k] <= '0;
            end
        end else if (digit_en) begin
            r_field_values[fsel] <= mul10_add_sat(cur_value, b[3:0]);
        end
    end

    for (genvar k = 0; k < NUM_DIST; k++) begin : g_dist
        if (k < FIELD_COUNT) begin : g_live
            assign field_out[k] =
                (status == ST_OK && r_field_index > FIDX_W'(k)) ? r_field_values[k] : '0;
        end else begin : g_zero
            assign field_out[k] = '0;
        end
    end

    always_comb begin
        o_result.status      = status;
        o_result.send_ack    = (status == ST_OK);
        o_result.field_count = (status == ST_OK) ? FCOUNT_W'(r_field_index) : '0;
        for (int k = 0; k < NUM_DIST; k++) begin
            o_result.distance[k] = field_out[k];
        end
    end

    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_field_index <= FIDX_W'(FIELD_COUNT))
        else $error("field index ran past the field count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= CNT_W'(MAX_FRAME))
        else $error("byte count ran past the frame limit");

    a_hunt_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HUNT) |-> (r_byte_count == '0 && !r_saw_flag && r_lrc == 8'h00))
        else $error("frame state not cleared while hunting");

    a_result_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> (r_phase == PH_HUNT))
        else $error("a result did not return the receiver to hunting");

endmodule

### rtl/core/irfr_out_stage.sv
module irfr_out_stage
    import irfr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic             i_res_valid,
    input  t_result          i_result,
    output logic             o_free,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata
);

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res_valid;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res_valid) begin
            r_result <= i_result;
        end
    end

    assign o_m_tvalid = r_valid;

    always_comb begin
        o_m_tdata[STATUS_W-1:0]                   = r_result.status;
        o_m_tdata[STATUS_W]                       = r_result.send_ack;
        o_m_tdata[STATUS_W+1 +: FCOUNT_W]         = r_result.field_count;
        for (int k = 0; k < NUM_DIST; k++) begin
            o_m_tdata[DIST_LSB + k*DIST_W +: DIST_W] = r_result.distance[k];
        end
    end

endmodule

### rtl/core/ir_reply_frame_receiver.sv
// Channel   Direction  tdata (lowest bit up)                          tuser
// s         in         rx_byte[7:0]                                   mode
// m         out        status[2:0], send_ack, field_count[3:0],       none
//                      distance_0 .. distance_7 (32 bits each)
//
// One item is taken per cycle while the result slot is free; a result is registered
// first as its byte in the input register, then in the result register.
// Reset is synchronous, active low, and returns the receiver to hunting for a start byte.
// A stalled result holds the input register and the parser; the result slot frees up in the
// same cycle that the waiting result is transferred out.
module ir_reply_frame_receiver
    import irfr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Input bytes or timeout events.
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [7:0]       i_s_tdata,   // rx_byte[7:0]
    input  logic             i_s_tuser,   // mode: 0 byte, 1 timeout
    // Frame results.
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata    // status, send_ack, field_count, distance_0..7
);

    logic    in_valid;
    t_item   in_item;
    logic    out_free;
    logic    step;
    logic    res_valid;
    t_result result;

    // The parser steps whenever an item waits and the result slot can take
    // whatever the item produces; bytes that produce nothing pass at the same rate.
    assign step = in_valid && out_free;

    irfr_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_take     (step),
        .o_valid    (in_valid),
        .o_item     (in_item)
    );

    // The parser holds the frame state (phase, running LRC, byte count, flag
    // check, field index and the field accumulators) and forms the result.
    irfr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (in_item),
        .o_res_valid (res_valid),
        .o_result    (result)
    );

    irfr_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (step),
        .i_res_valid (res_valid),
        .i_result    (result),
        .o_free      (out_free),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

### tb/sv/irfr_reply_check.sv
module irfr_reply_check
    import irfr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_s_tready,
    input  logic [7:0]       i_s_tdata,   // rx_byte[7:0]
    input  logic             i_s_tuser,   // mode
    input  logic             i_m_tvalid,
    input  logic             i_m_tready,
    input  logic [OUT_W-1:0] i_m_tdata,   // status, send_ack, field_count, distance_0..7
    output int               o_fail_count,
    output int               o_pending,
    output int               o_result_count,
    output int               o_ack_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Private copy of the receiver state.
    t_phase            rx_phase;
    logic [7:0]        lrc_acc;
    int unsigned       frame_len;
    logic              flag_ok;
    logic              flag_seen;
    int unsigned       fields_closed;
    logic [DIST_W-1:0] field_acc [NUM_DIST];

    t_result reply_q [$];
    int      fails   = 0;
    int      results = 0;
    int      acks    = 0;

    function automatic void enter_hunt();
        rx_phase      = PH_HUNT;
        lrc_acc       = '0;
        frame_len     = 0;
        flag_ok       = 1'b0;
        flag_seen     = 1'b0;
        fields_closed = 0;
    endfunction

    // Error replies carry only the status; an ok reply lists the closed fields.
    function automatic t_result reply_for(input t_status st);
        t_result r;
        r = '0;
        r.status = st;
        if (st == ST_OK) begin
            r.send_ack    = 1'b1;
            r.field_count = FCOUNT_W'(fields_closed);
            for (int k = 0; k < NUM_DIST && k < FIELD_COUNT; k++) begin
                if (k < fields_closed) begin
                    r.distance[k] = field_acc[k];
                end
            end
        end
        return r;
    endfunction

    // Advances the frame parser by one transfer; returns 1 when a reply is due.
    function automatic bit step_frame(input logic mode, input logic [7:0] b,
                                      output t_result r);
        logic [DIST_W+7:0] wide;
        r = '0;
        if (mode == MODE_TIMEOUT) begin
            r = reply_for(ST_TIMEOUT);
            enter_hunt();
            return 1'b1;
        end
        if (rx_phase != PH_BODY && rx_phase != PH_LRC) begin
            if (b == START_BYTE) begin
                enter_hunt();
                foreach (field_acc[k]) field_acc[k] = '0;
                rx_phase  = PH_BODY;
                frame_len = 1;
            end
            return 1'b0;
        end
        if (frame_len >= MAX_FRAME) begin
            r = reply_for(ST_LONG);
            enter_hunt();
            return 1'b1;
        end
        frame_len++;
        if (rx_phase == PH_LRC) begin
            if (!flag_ok) begin
                r = reply_for(ST_FLAG);
            end else if (b != lrc_acc) begin
                r = reply_for(ST_LRC);
            end else begin
                r = reply_for(ST_OK);
            end
            enter_hunt();
            return 1'b1;
        end
        lrc_acc ^= b;
        if (!flag_seen) begin
            flag_seen = 1'b1;
            flag_ok   = (b == FLAG_OK_BYTE);
            if (b == END_BYTE) begin
                rx_phase = PH_LRC;
            end
            return 1'b0;
        end
        if (b >= DIGIT_LO && b <= DIGIT_HI) begin
            if (fields_closed < FIELD_COUNT && fields_closed < NUM_DIST) begin
                wide = {8'b0, field_acc[fields_closed]} * 10 + (b - DIGIT_LO);
                if (wide > {8'b0, {DIST_W{1'b1}}}) begin
                    wide = {8'b0, {DIST_W{1'b1}}};
                end
                field_acc[fields_closed] = wide[DIST_W-1:0];
            end
        end else if (b == SEP_BYTE || b == END_BYTE) begin
            if (fields_closed < FIELD_COUNT && fields_closed < NUM_DIST) begin
                fields_closed++;
            end
            if (b == END_BYTE) begin
                rx_phase = PH_LRC;
            end
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        t_result got;
        t_result next_reply;
        if (!i_rst_n) begin
            enter_hunt();
            foreach (field_acc[k]) field_acc[k] = '0;
            reply_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                if (step_frame(i_s_tuser, i_s_tdata, next_reply)) begin
                    reply_q.push_back(next_reply);
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                results++;
                got.status      = t_status'(i_m_tdata[STATUS_W-1:0]);
                got.send_ack    = i_m_tdata[STATUS_W];
                got.field_count = i_m_tdata[STATUS_W+1 +: FCOUNT_W];
                for (int k = 0; k < NUM_DIST; k++) begin
                    got.distance[k] = i_m_tdata[DIST_LSB + k*DIST_W +: DIST_W];
                end
                if (reply_q.size() == 0) begin
                    fails++;
                    $error("reply with status %0d arrived with none outstanding",
                           got.status);
                end else begin
                    want = reply_q.pop_front();
                    if (want.send_ack) acks++;
                    if (got.status !== want.status) begin
                        fails++;
                        $error("status: expected %0d, got %0d", want.status, got.status);
                    end
                    if (got.send_ack !== want.send_ack) begin
                        fails++;
                        $error("send_ack: expected %0d, got %0d",
                               want.send_ack, got.send_ack);
                    end
                    if (got.field_count !== want.field_count) begin
                        fails++;
                        $error("field_count: expected %0d, got %0d",
                               want.field_count, got.field_count);
                    end
                    for (int k = 0; k < NUM_DIST; k++) begin
                        if (got.distance[k] !== want.distance[k]) begin
                            fails++;
                            $error("distance_%0d: expected %0d, got %0d",
                                   k, want.distance[k], got.distance[k]);
                        end
                    end
                end
            end
        end
        o_pending      <= reply_q.size();
        o_fail_count   <= fails;
        o_result_count <= results;
        o_ack_count    <= acks;
    end

endmodule

### tb/sv/ir_reply_frame_receiver_tb.sv
module ir_reply_frame_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import irfr_pkg::*;

    localparam int ITEM_TARGET    = 1850;
    localparam int LONG_HOLD      = 300;   // receiver hold-off used to back the block up
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer on either side
    localparam int SETTLE_CYCLES  = 8;     // wait after the final drain

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_s_tvalid = 1'b0;
    logic [7:0]       i_s_tdata  = '0;      // rx_byte[7:0]
    logic             i_s_tuser  = MODE_BYTE; // mode
    logic             o_s_tready;
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    logic [OUT_W-1:0] o_m_tdata;            // status, send_ack, field_count, distance_0..7

    int fail_count;
    int pending;
    int result_count;
    int ack_count;

    // Shared knobs between the stimulus and the receiver process. The idle
    // percentages are reshuffled every few frames so that some stretches run
    // with no idling at all; calm switches idling off for the tail of the run.
    int unsigned src_pct  = 0;
    int unsigned sink_pct = 0;
    bit          calm      = 1'b0;
    bit          hold_long = 1'b0;
    int unsigned items_sent = 0;
    int unsigned stall_cycles = 0;

    // Body of the frame being built: flag byte up to and including the LRC.
    // The start byte is added when the frame is sent.
    logic [7:0] frame_bytes [$];

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    ir_reply_frame_receiver DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    irfr_reply_check u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (i_s_tvalid),
        .i_s_tready     (o_s_tready),
        .i_s_tdata      (i_s_tdata),
        .i_s_tuser      (i_s_tuser),
        .i_m_tvalid     (o_m_tvalid),
        .i_m_tready     (i_m_tready),
        .i_m_tdata      (o_m_tdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_ack_count    (ack_count)
    );

    // Watchdog: a run that stops moving on both channels is a hang.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("ir_reply_frame_receiver_tb: FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Result side. Ready drops in random bursts, and once for a long stretch
    // on request so that both pipeline registers fill and the input stalls.
    initial begin : sink_proc
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                i_m_tready <= 1'b0;
            end else if (hold_long) begin
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_long = 1'b0;
            end else if (!calm && $urandom_range(0, 99) < sink_pct) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(0, 15)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Offers one transfer and returns at the edge where it is taken. Valid is
    // only lowered when an idle burst follows, so a back-to-back transfer
    // never sees valid dropped and raised in the same time step.
    task automatic push_item(input logic mode, input logic [7:0] b, input bit counted);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_tready);
        if (counted) items_sent++;
        if (!calm && $urandom_range(0, 99) < src_pct) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    // Waits until every reply predicted so far has come out. The checker
    // publishes its count through a register, so the task waits for an edge before it looks.
    task automatic drain_replies();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic void open_frame(input logic [7:0] flag);
        frame_bytes.delete();
        frame_bytes.push_back(flag);
    endfunction

    function automatic void add_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            frame_bytes.push_back(s[k]);
        end
    endfunction

    function automatic void add_digits(input int unsigned n);
        repeat (n) frame_bytes.push_back(DIGIT_LO + 8'($urandom_range(0, 9)));
    endfunction

    // Appends the end byte and the XOR LRC over flag through end byte;
    // a nonzero lrc_err corrupts the check byte on purpose.
    function automatic void close_frame(input logic [7:0] lrc_err);
        logic [7:0] lrc;
        lrc = '0;
        frame_bytes.push_back(END_BYTE);
        foreach (frame_bytes[k]) lrc ^= frame_bytes[k];
        frame_bytes.push_back(lrc ^ lrc_err);
    endfunction

    task automatic send_frame();
        push_item(MODE_BYTE, START_BYTE, 1'b1);
        foreach (frame_bytes[k]) push_item(MODE_BYTE, frame_bytes[k], 1'b1);
    endtask

    // A frame with n bytes ahead of the end byte, flag included. Up to 252
    // the frame fits; from 253 on the receiver reports it as too long.
    task automatic send_long_frame(input int unsigned n);
        open_frame(FLAG_OK_BYTE);
        repeat (n - 1) begin
            if ($urandom_range(0, 99) < 15) begin
                frame_bytes.push_back(SEP_BYTE);
            end else begin
                add_digits(1);
            end
        end
        close_frame(8'h00);
        send_frame();
    endtask

    // Mostly well-formed frames with random fields, plus long frames, corrupted
    // flags and checks, stray bytes in the body, timeouts at random points and noise.
    task automatic random_frame();
        int unsigned kind;
        int unsigned n_fields;
        int unsigned cut;
        kind = $urandom_range(0, 199);
        if (kind < 6) begin
            send_long_frame($urandom_range(251, 254));
        end else if (kind < 14) begin
            // Line noise while hunting; ignored unless it hits a start byte.
            repeat ($urandom_range(1, 6)) push_item(MODE_BYTE, 8'($urandom), 1'b0);
        end else if (kind < 22) begin
            push_item(MODE_TIMEOUT, 8'($urandom), 1'b1);
        end else begin
            open_frame((kind < 36) ? 8'($urandom) : FLAG_OK_BYTE);
            n_fields = $urandom_range(0, 11);
            for (int f = 0; f < n_fields; f++) begin
                add_digits(($urandom_range(0, 4) == 0) ? $urandom_range(8, 12)
                                                       : $urandom_range(0, 4));
                if ($urandom_range(0, 99) < 4) frame_bytes.push_back(8'($urandom));
                if (f + 1 < n_fields) frame_bytes.push_back(SEP_BYTE);
            end
            close_frame((kind < 50) ? 8'($urandom_range(1, 255)) : 8'h00);
            if (kind < 185) begin
                send_frame();
            end else begin
                // Cut the frame short with a timeout, possibly in the LRC phase.
                cut = $urandom_range(0, frame_bytes.size() - 1);
                push_item(MODE_BYTE, START_BYTE, 1'b1);
                for (int k = 0; k < cut; k++) push_item(MODE_BYTE, frame_bytes[k], 1'b1);
                push_item(MODE_TIMEOUT, 8'($urandom), 1'b1);
            end
        end
    endtask

    initial begin : stimulus
        int unsigned frames;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Stray bytes and a timeout while hunting.
        push_item(MODE_BYTE, 8'hFF, 1'b1);
        push_item(MODE_BYTE, 8'h00, 1'b1);
        push_item(MODE_TIMEOUT, 8'hFF, 1'b1);
        // A plain good frame.
        open_frame(FLAG_OK_BYTE);
        add_text("1;22;333");
        close_frame(8'h00);
        send_frame();
        // No fields at all still closes one empty field at the end byte.
        open_frame(FLAG_OK_BYTE);
        close_frame(8'h00);
        send_frame();
        // Empty fields between separators.
        open_frame(FLAG_OK_BYTE);
        add_text(";;7");
        close_frame(8'h00);
        send_frame();
        // Largest value that fits, one past it, and a far larger one.
        open_frame(FLAG_OK_BYTE);
        add_text("4294967295;4294967296;99999999999");
        close_frame(8'h00);
        send_frame();
        // More fields than the receiver keeps.
        open_frame(FLAG_OK_BYTE);
        add_text("1;2;3;4;5;6;7;8;9;10");
        close_frame(8'h00);
        send_frame();
        // Bad flag, and a flag equal to the end byte that ends the body at once.
        open_frame(8'h31);
        add_text("12");
        close_frame(8'h00);
        send_frame();
        open_frame(END_BYTE);
        frame_bytes.push_back(END_BYTE);
        send_frame();
        // Wrong check byte.
        open_frame(FLAG_OK_BYTE);
        add_text("5");
        close_frame(8'h80);
        send_frame();
        // Other bytes, a second start byte among them, only enter the LRC.
        open_frame(FLAG_OK_BYTE);
        add_text("1A2");
        frame_bytes.push_back(START_BYTE);
        add_text("3");
        close_frame(8'h00);
        send_frame();
        // Timeouts in the middle of the body and while waiting for the LRC.
        push_item(MODE_BYTE, START_BYTE, 1'b1);
        push_item(MODE_BYTE, FLAG_OK_BYTE, 1'b1);
        push_item(MODE_BYTE, DIGIT_HI, 1'b1);
        push_item(MODE_TIMEOUT, 8'h00, 1'b1);
        push_item(MODE_BYTE, START_BYTE, 1'b1);
        push_item(MODE_BYTE, FLAG_OK_BYTE, 1'b1);
        push_item(MODE_BYTE, END_BYTE, 1'b1);
        push_item(MODE_TIMEOUT, 8'h55, 1'b1);
        // The longest frame that fits, then one that is too long.
        send_long_frame(252);
        send_long_frame(260);
        push_item(MODE_TIMEOUT, 8'hAA, 1'b1);

        // Random part.
        frames = 0;
        while (items_sent < ITEM_TARGET) begin
            if (frames % 12 == 0) begin
                case ($urandom_range(0, 2))
                    0: src_pct = 0;
                    1: src_pct = 8;
                    default: src_pct = 30;
                endcase
                case ($urandom_range(0, 2))
                    0: sink_pct = 0;
                    1: sink_pct = 8;
                    default: sink_pct = 30;
                endcase
            end
            if (frames == 4) begin
                // Every timeout makes a reply, so a burst of them backs the
                // block up while the receiver is held off.
                hold_long = 1'b1;
                repeat (12) push_item(MODE_TIMEOUT, 8'($urandom), 1'b1);
            end
            if (frames == 12) begin
                drain_replies();
            end
            if (items_sent >= ITEM_TARGET * 85 / 100) begin
                calm = 1'b1;
            end
            random_frame();
            frames++;
        end

        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d input transfers in %0d random frames after the directed set;",
                 items_sent, frames);
        $display("checked %0d replies, %0d with ACK, with a %0d-cycle output hold-off.",
                 result_count, ack_count, LONG_HOLD);
        if (fail_count == 0) begin
            $display("ir_reply_frame_receiver_tb: PASS");
        end else begin
            $display("ir_reply_frame_receiver_tb: FAIL");
        end
        $finish;
    end

endmodule

### ir_reply_frame_receiver.f
rtl/core/irfr_pkg.sv
rtl/core/irfr_in_stage.sv
rtl/core/irfr_parser.sv
rtl/core/irfr_out_stage.sv
rtl/core/ir_reply_frame_receiver.sv
tb/sv/irfr_reply_check.sv
tb/sv/ir_reply_frame_receiver_tb.sv
